// ===== hdl/ncm_pkg.sv =====
package ncm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + 2;
   localparam int DEN_W    = SAMPLE_W + 1;
   localparam int PROD_W   = 2 * DEN_W;
   localparam int INDEX_W  = 1;

   localparam logic [INDEX_W-1:0] REG_BRIGHTNESS_LIMIT = 1'b0;
   localparam logic [INDEX_W-1:0] REG_SNOW_INDEX_LIMIT = 1'b1;

   localparam logic [SAMPLE_W-1:0] RST_BRIGHTNESS_LIMIT = 16'd26226;
   localparam logic [SAMPLE_W-1:0] RST_SNOW_INDEX_LIMIT = 16'd42598;
   localparam logic [SAMPLE_W-1:0] SNOW_CODE_ZERO_DEN   = 16'd32768;
   localparam logic [SAMPLE_W-1:0] SNOW_CODE_MAX        = 16'hFFFF;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] near_ir;
   } pixel_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] brightness_limit;
      logic [SAMPLE_W-1:0] snow_index_limit;
   } limits_type;

   typedef struct packed {
      pixel_type        pix;
      logic [SUM_W-1:0] sum;
      logic [DEN_W-1:0] den;
   } sum_type;

   typedef struct packed {
      pixel_type         pix;
      logic              bright;
      logic              den_zero;
      logic [PROD_W-1:0] prod;
   } prod_type;

   typedef struct packed {
      pixel_type pix;
      logic      cloud;
   } result_type;

endpackage

// ===== hdl/ncm_sum_stage.sv =====
module ncm_sum_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ncm_pkg::pixel_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output ncm_pkg::sum_type  out_data
);
   import ncm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   sum_type data_ff;
   sum_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.pix = in_pix;
      data_in.sum = SUM_W'(in_pix.red) + SUM_W'(in_pix.green)
                  + SUM_W'(in_pix.blue) + SUM_W'(in_pix.near_ir);
      data_in.den = DEN_W'(in_pix.green) + DEN_W'(in_pix.near_ir);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/ncm_mul_stage.sv =====
module ncm_mul_stage (
   input  logic               clock,
   input  logic               reset,
   input  ncm_pkg::limits_type limits,
   input  logic               in_valid,
   output logic               in_ready,
   input  ncm_pkg::sum_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ncm_pkg::prod_type  out_data
);
   import ncm_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   prod_type          data_ff;
   prod_type          data_in;
   logic [SAMPLE_W-1:0] quot;
   logic [1:0]          frac;
   logic                round_up;
   logic [SAMPLE_W:0]   mean;
   logic [DEN_W-1:0]    limit_odd;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Mean of four samples, rounded to nearest with ties to even.
   always_comb begin
      quot      = in_data.sum[SUM_W-1:2];
      frac      = in_data.sum[1:0];
      round_up  = (frac == 2'd3) || ((frac == 2'd2) && quot[0]);
      mean      = {1'b0, quot} + (SAMPLE_W + 1)'(round_up);
      limit_odd = {limits.snow_index_limit, 1'b1};

      data_in.pix      = in_data.pix;
      data_in.bright   = mean > {1'b0, limits.brightness_limit};
      data_in.den_zero = in_data.den == '0;
      data_in.prod     = PROD_W'(limit_odd) * PROD_W'(in_data.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/ncm_decide_stage.sv =====
module ncm_decide_stage (
   input  logic                clock,
   input  logic                reset,
   input  ncm_pkg::limits_type  limits,
   input  logic                in_valid,
   output logic                in_ready,
   input  ncm_pkg::prod_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ncm_pkg::result_type  out_data
);
   import ncm_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   result_type        data_ff;
   result_type        data_in;
   logic [PROD_W-1:0] scaled_green;
   logic              below_half;
   logic              at_half;
   logic              not_snow;
   logic              cloud;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // The rounded code is at most the limit when 2*65536*green is below
   // (2*limit+1)*(green+near_ir), or equal to it with an even limit.
   always_comb begin
      scaled_green = {1'b0, in_data.pix.green, {(DEN_W){1'b0}}};
      below_half   = scaled_green < in_data.prod;
      at_half      = (scaled_green == in_data.prod) && !limits.snow_index_limit[0];
      if (limits.snow_index_limit == SNOW_CODE_MAX) begin
         not_snow = 1'b1;
      end else if (in_data.den_zero) begin
         not_snow = SNOW_CODE_ZERO_DEN <= limits.snow_index_limit;
      end else begin
         not_snow = below_half || at_half;
      end
      cloud = in_data.bright && not_snow;

      data_in.cloud = cloud;
      data_in.pix   = cloud ? '0 : in_data.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/ndsi_cloud_mask.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  red, green, blue, near_ir
// rsp       out        rsp_valid/rsp_ready  out_red, out_green, out_blue, out_near_ir, cloud
// csr       in         csr_we               csr_index, csr_wdata
//
// Each pixel passes through three register stages (sums, multiply, compare)
// from req to rsp; the stages accept one pixel every cycle unless stalled.
// A stage holds its pixel while the stage after it is full and stalled.
// Reset empties all stages and loads both limits with their default values.
module ndsi_cloud_mask (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ncm_pkg::SAMPLE_W-1:0]      req_red,
   input  logic [ncm_pkg::SAMPLE_W-1:0]      req_green,
   input  logic [ncm_pkg::SAMPLE_W-1:0]      req_blue,
   input  logic [ncm_pkg::SAMPLE_W-1:0]      req_near_ir,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ncm_pkg::SAMPLE_W-1:0]      rsp_out_red,
   output logic [ncm_pkg::SAMPLE_W-1:0]      rsp_out_green,
   output logic [ncm_pkg::SAMPLE_W-1:0]      rsp_out_blue,
   output logic [ncm_pkg::SAMPLE_W-1:0]      rsp_out_near_ir,
   output logic                              rsp_cloud,
   input  logic                              csr_we,
   input  logic [ncm_pkg::INDEX_W-1:0]       csr_index,
   input  logic [ncm_pkg::SAMPLE_W-1:0]      csr_wdata
);
   import ncm_pkg::*;

   logic [SAMPLE_W-1:0] brightness_limit_ff;
   logic [SAMPLE_W-1:0] brightness_limit_in;
   logic [SAMPLE_W-1:0] snow_index_limit_ff;
   logic [SAMPLE_W-1:0] snow_index_limit_in;
   limits_type          limits;
   pixel_type           req_pix;
   logic                sum_valid;
   logic                sum_ready;
   sum_type             sum_data;
   logic                prod_valid;
   logic                prod_ready;
   prod_type            prod_data;
   result_type          rsp_data;

   always_comb begin
      brightness_limit_in = brightness_limit_ff;
      snow_index_limit_in = snow_index_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BRIGHTNESS_LIMIT: brightness_limit_in = csr_wdata;
            REG_SNOW_INDEX_LIMIT: snow_index_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_limit_ff <= RST_BRIGHTNESS_LIMIT;
         snow_index_limit_ff <= RST_SNOW_INDEX_LIMIT;
      end else begin
         brightness_limit_ff <= brightness_limit_in;
         snow_index_limit_ff <= snow_index_limit_in;
      end
   end

   assign limits.brightness_limit = brightness_limit_ff;
   assign limits.snow_index_limit = snow_index_limit_ff;

   assign req_pix.red     = req_red;
   assign req_pix.green   = req_green;
   assign req_pix.blue    = req_blue;
   assign req_pix.near_ir = req_near_ir;

   ncm_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pix    (req_pix),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   ncm_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   ncm_decide_stage u_decide (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_out_red     = rsp_data.pix.red;
   assign rsp_out_green   = rsp_data.pix.green;
   assign rsp_out_blue    = rsp_data.pix.blue;
   assign rsp_out_near_ir = rsp_data.pix.near_ir;
   assign rsp_cloud       = rsp_data.cloud;

endmodule

// ===== hdl/ncm_checker.sv =====
module ncm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ncm_pkg::SAMPLE_W-1:0] rsp_out_red,
   input logic [ncm_pkg::SAMPLE_W-1:0] rsp_out_green,
   input logic [ncm_pkg::SAMPLE_W-1:0] rsp_out_blue,
   input logic [ncm_pkg::SAMPLE_W-1:0] rsp_out_near_ir,
   input logic                         rsp_cloud
);
   import ncm_pkg::*;

   // A cloudy pixel leaves with all four samples cleared.
   a_cloud_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cloud) |-> (rsp_out_red == '0) && (rsp_out_green == '0)
         && (rsp_out_blue == '0) && (rsp_out_near_ir == '0))
      else $error("cloudy pixel with nonzero samples");

   // An output stage that is empty or draining lets the input side take a transfer.
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while the output stage can move");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_cloud)
         && $stable(rsp_out_red) && $stable(rsp_out_green)
         && $stable(rsp_out_blue) && $stable(rsp_out_near_ir))
      else $error("stalled result changed");

endmodule

bind ndsi_cloud_mask ncm_checker u_ncm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_red     (rsp_out_red),
   .rsp_out_green   (rsp_out_green),
   .rsp_out_blue    (rsp_out_blue),
   .rsp_out_near_ir (rsp_out_near_ir),
   .rsp_cloud       (rsp_cloud)
);

// ===== tb/sv/ndsi_cloud_mask_tb.sv =====
`timescale 1ns / 100ps

module ndsi_cloud_mask_tb;
   import ncm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT    = 37;
   localparam int REPORT_MAX  = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_red = '0;
   logic [SAMPLE_W-1:0] req_green = '0;
   logic [SAMPLE_W-1:0] req_blue = '0;
   logic [SAMPLE_W-1:0] req_near_ir = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_out_red;
   logic [SAMPLE_W-1:0] rsp_out_green;
   logic [SAMPLE_W-1:0] rsp_out_blue;
   logic [SAMPLE_W-1:0] rsp_out_near_ir;
   logic                rsp_cloud;
   logic                csr_we = 1'b0;
   logic [INDEX_W-1:0]  csr_index = REG_BRIGHTNESS_LIMIT;
   logic [SAMPLE_W-1:0] csr_wdata = '0;

   pixel_type  pixel_queue[$];
   result_type expected_pixels[$];
   limits_type limits = '{RST_BRIGHTNESS_LIMIT, RST_SNOW_INDEX_LIMIT};

   logic       req_xfer = 1'b0;
   pixel_type  next_pixel;
   pixel_type  seen_pixel;
   result_type want;
   result_type got;
   int         idle_pct = IDLE_PCT;
   int         hold_requests = 0;
   int         hold_served = 0;
   int         hold_left = 0;
   int         pixels_issued = 0;
   int         pixels_checked = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   ndsi_cloud_mask dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_near_ir     (req_near_ir),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_near_ir (rsp_out_near_ir),
      .rsp_cloud       (rsp_cloud),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic result_type mask_pixel(pixel_type p, limits_type lim);
      logic [SUM_W-1:0]    total;
      logic [SAMPLE_W:0]   mean;
      longint unsigned     den;
      longint unsigned     num;
      longint unsigned     code;
      longint unsigned     rem;
      logic                cloud;
      result_type          res;
      total = SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue) + SUM_W'(p.near_ir);
      mean = {1'b0, total[SUM_W-1:2]};
      if (total[1:0] == 2'd3 || (total[1:0] == 2'd2 && mean[0])) begin
         mean = mean + 1'b1;
      end
      den = 64'(p.green);
      den = den + 64'(p.near_ir);
      if (den == 0) begin
         code = 64'(SNOW_CODE_ZERO_DEN);
      end else begin
         num = 64'(p.green);
         num = num << 16;
         code = num / den;
         rem = num % den;
         if (2 * rem > den || (2 * rem == den && code[0])) begin
            code = code + 1;
         end
         if (code > 64'(SNOW_CODE_MAX)) begin
            code = 64'(SNOW_CODE_MAX);
         end
      end
      cloud = (mean > {1'b0, lim.brightness_limit})
              && (code <= 64'(lim.snow_index_limit));
      res.pix = cloud ? '0 : p;
      res.cloud = cloud;
      return res;
   endfunction

   task automatic note_mismatch(string what, result_type exp_res, result_type act_res);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("%s: expected r=%h g=%h b=%h n=%h cloud=%b", what, exp_res.pix.red,
                  exp_res.pix.green, exp_res.pix.blue, exp_res.pix.near_ir, exp_res.cloud);
         $display("   actual r=%h g=%h b=%h n=%h cloud=%b", act_res.pix.red,
                  act_res.pix.green, act_res.pix.blue, act_res.pix.near_ir, act_res.cloud);
      end
   endtask

   // Input driver: a new pixel may be presented once the previous one has transferred.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_pixel = pixel_queue.pop_front();
            req_valid <= 1'b1;
            req_red <= next_pixel.red;
            req_green <= next_pixel.green;
            req_blue <= next_pixel.blue;
            req_near_ir <= next_pixel.near_ir;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      req_xfer <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.pix.red = rsp_out_red;
            got.pix.green = rsp_out_green;
            got.pix.blue = rsp_out_blue;
            got.pix.near_ir = rsp_out_near_ir;
            got.cloud = rsp_cloud;
            if (expected_pixels.size() == 0) begin
               note_mismatch("unexpected transfer", got, got);
            end else begin
               want = expected_pixels.pop_front();
               if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
                   got.pix.blue !== want.pix.blue || got.pix.near_ir !== want.pix.near_ir ||
                   got.cloud !== want.cloud) begin
                  note_mismatch("result mismatch", want, got);
               end
            end
            pixels_checked++;
         end
         if (req_valid && req_ready) begin
            seen_pixel.red = req_red;
            seen_pixel.green = req_green;
            seen_pixel.blue = req_blue;
            seen_pixel.near_ir = req_near_ir;
            expected_pixels.push_back(mask_pixel(seen_pixel, limits));
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ndsi_cloud_mask] ERROR");
         $finish;
      end
   end

   task automatic push_pixel(int r, int g, int b, int n);
      pixel_type p;
      p.red = SAMPLE_W'(r);
      p.green = SAMPLE_W'(g);
      p.blue = SAMPLE_W'(b);
      p.near_ir = SAMPLE_W'(n);
      pixel_queue.push_back(p);
      pixels_issued++;
   endtask

   task automatic push_random_pixel();
      int r;
      int g;
      int b;
      int n;
      r = $urandom_range(65535);
      g = $urandom_range(65535);
      b = $urandom_range(65535);
      n = $urandom_range(65535);
      case ($urandom_range(5))
         0: ;
         1: begin
            r = $urandom_range(65535, 30000);
            b = $urandom_range(65535, 30000);
            n = $urandom_range(65535, g);
         end
         2: begin
            g = $urandom_range(65535, 30000);
            n = $urandom_range(g / 4);
         end
         3: begin
            r = $urandom_range(255);
            g = $urandom_range(255);
            b = $urandom_range(255);
            n = $urandom_range(255);
         end
         4: begin
            if ($urandom_range(2) == 0) r = 0; else if ($urandom_range(1)) r = 65535;
            if ($urandom_range(2) == 0) g = 0; else if ($urandom_range(1)) g = 65535;
            if ($urandom_range(2) == 0) b = 0; else if ($urandom_range(1)) b = 65535;
            if ($urandom_range(2) == 0) n = 0; else if ($urandom_range(1)) n = 65535;
         end
         default: begin
            if ($urandom_range(1)) g = 0; else n = 0;
         end
      endcase
      push_pixel(r, g, b, n);
   endtask

   task automatic write_limit(logic [INDEX_W-1:0] index, logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == REG_BRIGHTNESS_LIMIT) begin
         limits.brightness_limit = value;
      end else begin
         limits.snow_index_limit = value;
      end
   endtask

   task automatic drain_pipeline();
      while (pixels_checked < pixels_issued) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(int bright_lim, int snow_lim, int count);
      write_limit(REG_BRIGHTNESS_LIMIT, SAMPLE_W'(bright_lim));
      write_limit(REG_SNOW_INDEX_LIMIT, SAMPLE_W'(snow_lim));
      @(posedge clock);
      push_pixel(bright_lim, bright_lim, bright_lim, bright_lim);
      if (bright_lim < 65535) begin
         push_pixel(bright_lim + 1, bright_lim + 1, bright_lim + 1, bright_lim + 1);
      end
      repeat (count) push_random_pixel();
      drain_pipeline();
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Default limits straight out of reset.
      @(posedge clock);
      push_pixel(0, 0, 0, 0);
      push_pixel(65535, 65535, 65535, 65535);
      push_pixel(65535, 0, 65535, 0);
      push_pixel(65535, 65535, 65535, 0);
      push_pixel(0, 1, 0, 0);
      push_pixel(65535, 0, 65535, 65535);
      push_pixel(26226, 26226, 26226, 26226);
      push_pixel(26227, 26227, 26227, 26227);
      push_pixel(26226, 26226, 26226, 26228);
      push_pixel(26227, 26227, 26227, 26229);
      push_pixel(26226, 26226, 26226, 26229);
      push_pixel(26226, 26226, 26226, 26227);
      push_pixel(65535, 13, 65535, 7);
      push_pixel(65535, 13001, 65535, 6999);
      push_pixel(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
      push_pixel(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
      repeat (120) push_random_pixel();
      drain_pipeline();

      run_phase(0, 0, 80);
      run_phase(65535, 65535, 80);
      run_phase(0, 65535, 80);

      // The receiver holds off for a long stretch while the sender keeps offering.
      write_limit(REG_BRIGHTNESS_LIMIT, RST_BRIGHTNESS_LIMIT);
      write_limit(REG_SNOW_INDEX_LIMIT, 16'd32768);
      @(posedge clock);
      hold_requests++;
      repeat (140) push_random_pixel();
      drain_pipeline();

      idle_pct = 0;
      run_phase(30000, 32767, 140);
      idle_pct = IDLE_PCT;

      repeat (4) begin
         run_phase($urandom_range(65535), $urandom_range(65535), 65);
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("[ndsi_cloud_mask] OK");
      end else begin
         $display("[ndsi_cloud_mask] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ncm_pkg.sv
hdl/ncm_sum_stage.sv
hdl/ncm_mul_stage.sv
hdl/ncm_decide_stage.sv
hdl/ndsi_cloud_mask.sv
hdl/ncm_checker.sv
tb/sv/ndsi_cloud_mask_tb.sv
